// ----- rtl/bdcm_pkg.sv -----
// ----------------------------------------------------------------------------
// bdcm_pkg
// Shared types, constants and helpers for the battery discharge channel
// monitor: beat payloads, register indexes, verdict codes and timer step.
// ----------------------------------------------------------------------------
package bdcm_pkg;

    // Channel count and the most results one input beat may produce.
    localparam int NUM_CHANNELS = 4;
    localparam int CHAN_W       = 2;
    localparam int REPORT_MAX   = 4;
    localparam int CNT_W        = $clog2(REPORT_MAX + 1);

    // Field widths.
    localparam int READING_W = 10;
    localparam int HOURS_W   = 8;
    localparam int MINUTES_W = 6;
    localparam int SECONDS_W = 6;

    // Timer limits.
    localparam logic [SECONDS_W-1:0] SEC_LAST  = SECONDS_W'(59);
    localparam logic [MINUTES_W-1:0] MIN_LAST  = MINUTES_W'(59);
    localparam logic [HOURS_W-1:0]   HOUR_MAX  = HOURS_W'(255);

    // Register reset values.
    localparam logic [READING_W-1:0] RESET_THRESHOLD = READING_W'(200);
    localparam logic [READING_W-1:0] RESET_LOCK_LOW  = READING_W'(80);
    localparam logic [READING_W-1:0] RESET_LOCK_HIGH = READING_W'(200);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_LOCK_LOW  = 2'd1,
        REG_LOCK_HIGH = 2'd2
    } reg_index_t;

    // Input operation codes.
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    // Channel verdict codes.
    typedef enum logic [1:0] {
        VERDICT_NONE     = 2'd0,
        VERDICT_COMPLETE = 2'd1,
        VERDICT_ABSENT   = 2'd2
    } verdict_t;

    // Input beat payload.
    typedef struct packed {
        op_t                  operation;
        logic [CHAN_W-1:0]    channel;
        logic [READING_W-1:0] sample;
    } in_item_t;

    // Result beat payload.
    typedef struct packed {
        logic [CHAN_W-1:0]    out_channel;
        logic                 discharge_on;
        logic                 locked;
        verdict_t             status;
        logic [HOURS_W-1:0]   hours;
        logic [MINUTES_W-1:0] minutes;
        logic [SECONDS_W-1:0] seconds;
        logic                 last;
    } out_item_t;

    // Per-channel state.
    typedef struct packed {
        logic [READING_W-1:0] reading;
        logic                 lock;
        verdict_t             verdict;
        logic [HOURS_W-1:0]   hours;
        logic [MINUTES_W-1:0] minutes;
        logic [SECONDS_W-1:0] seconds;
    } chan_state_t;

    // One-second step of an h:m:s timer; hours saturate.
    function automatic chan_state_t timer_step(input chan_state_t cur);
        chan_state_t nxt;
        nxt = cur;
        if (cur.seconds == SEC_LAST)
        begin
            nxt.seconds = '0;
            if (cur.minutes == MIN_LAST)
            begin
                nxt.minutes = '0;
                if (cur.hours != HOUR_MAX)
                begin
                    nxt.hours = cur.hours + HOURS_W'(1);
                end
            end
            else
            begin
                nxt.minutes = cur.minutes + MINUTES_W'(1);
            end
        end
        else
        begin
            nxt.seconds = cur.seconds + SECONDS_W'(1);
        end
        return nxt;
    endfunction

endpackage

// ----- rtl/battery_discharge_channel_monitor.sv -----
// ----------------------------------------------------------------------------
// battery_discharge_channel_monitor
// Tracks four battery discharge channels: switch state, lock verdict and an
// h:m:s discharge timer per channel, driven by voltage samples and ticks.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                          | Beat
//  ---------+----------------------------------+-------------------------------
//  in       | in_valid, in_ready, in_data      | sample for one channel, or tick
//  out      | out_valid, out_ready, out_data   | one channel report
//  config   | cfg_we, cfg_index, cfg_wdata     | one register write
//
//  A sample beat yields one report, a tick beat four, one per channel in order.
//  The input beat is processed in the cycle it is accepted; its reports sit in
//  a four-entry result buffer, drained in order by the single output port.
//  A new beat is accepted while the final buffered report is being taken.
//  Reset clears all channel state and loads the register defaults.
//
module battery_discharge_channel_monitor
    import bdcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_we,
    input  reg_index_t cfg_index,
    input  logic [READING_W-1:0] cfg_wdata
);

    logic [READING_W-1:0] threshold_reg;
    logic [READING_W-1:0] lock_low_reg;
    logic [READING_W-1:0] lock_high_reg;

    chan_state_t chan_reg  [NUM_CHANNELS];
    chan_state_t chan_next [NUM_CHANNELS];
    out_item_t   res_reg   [REPORT_MAX];
    out_item_t   res_next  [REPORT_MAX];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic        in_accept;
    logic        out_take;

    // Handshake: accept when the buffer is empty or its final report leaves now.
    assign out_valid = (cnt_reg != '0);
    assign out_data  = res_reg[0];
    assign out_take  = out_valid && out_ready;
    assign in_ready  = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_ready);
    assign in_accept = in_valid && in_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= RESET_THRESHOLD;
            lock_low_reg  <= RESET_LOCK_LOW;
            lock_high_reg <= RESET_LOCK_HIGH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_wdata;
                REG_LOCK_LOW:  lock_low_reg  <= cfg_wdata;
                REG_LOCK_HIGH: lock_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Channel update and result buffer loading.
    always_comb
    begin
        chan_state_t cur;
        chan_state_t upd;
        logic        run;
        logic        on;

        chan_next = chan_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        cur       = chan_reg[in_data.channel];
        upd       = cur;
        run       = 1'b0;
        on        = 1'b0;

        // Drain: shift the buffer down by one report.
        if (out_take)
        begin
            for (int i = 0; i < REPORT_MAX - 1; i++)
            begin
                res_next[i] = res_reg[i+1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end

        if (in_accept)
        begin
            unique case (in_data.operation)
                OP_SAMPLE:
                begin
                    // Switch test uses the lock state from before this sample.
                    on = !cur.lock && (in_data.sample >= threshold_reg);
                    if ((in_data.sample < lock_high_reg) && (in_data.sample > lock_low_reg))
                    begin
                        upd.lock    = 1'b1;
                        upd.verdict = VERDICT_COMPLETE;
                    end
                    else if (in_data.sample < lock_low_reg)
                    begin
                        upd.lock    = 1'b0;
                        upd.verdict = VERDICT_ABSENT;
                        upd.hours   = '0;
                        upd.minutes = '0;
                        upd.seconds = '0;
                    end
                    upd.reading = in_data.sample;
                    chan_next[in_data.channel] = upd;

                    res_next[0].out_channel  = in_data.channel;
                    res_next[0].discharge_on = on;
                    res_next[0].locked       = upd.lock;
                    res_next[0].status       = upd.verdict;
                    res_next[0].hours        = upd.hours;
                    res_next[0].minutes      = upd.minutes;
                    res_next[0].seconds      = upd.seconds;
                    res_next[0].last         = 1'b1;
                    cnt_next = CNT_W'(1);
                end
                OP_TICK:
                begin
                    // Advance every running channel, then report each one.
                    for (int c = 0; c < NUM_CHANNELS; c++)
                    begin
                        run = !chan_reg[c].lock && (chan_reg[c].reading >= threshold_reg);
                        if (run)
                        begin
                            chan_next[c] = timer_step(chan_reg[c]);
                        end
                    end
                    for (int c = 0; c < REPORT_MAX; c++)
                    begin
                        res_next[c].out_channel  = CHAN_W'(c);
                        res_next[c].discharge_on = !chan_next[c].lock &&
                                                   (chan_next[c].reading >= threshold_reg);
                        res_next[c].locked       = chan_next[c].lock;
                        res_next[c].status       = chan_next[c].verdict;
                        res_next[c].hours        = chan_next[c].hours;
                        res_next[c].minutes      = chan_next[c].minutes;
                        res_next[c].seconds      = chan_next[c].seconds;
                        res_next[c].last         = (c == REPORT_MAX - 1);
                    end
                    cnt_next = CNT_W'(REPORT_MAX);
                end
                default: ;
            endcase
        end
    end

    // Channel state and buffer fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                chan_reg[c] <= '0;
            end
            cnt_reg <= '0;
        end
        else
        begin
            chan_reg <= chan_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Result buffer payload.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule
